// File: design/tte_pkg.sv
// Package for the tap tempo estimator: constants, control word and microprogram.
`timescale 1ns / 1ps

package tte_pkg;

    localparam int          WINDOW_TAPS_DEF = 8;
    localparam int unsigned MS_PER_MINUTE   = 60000;
    localparam logic [8:0]  MIN_TEMPO_RESET = 9'd30;
    localparam int          MIN_TEMPO_W     = 9;
    localparam int          TIME_W          = 32;
    localparam int          TEMPO_W         = 16;
    localparam int          TAPS_W          = 4;
    localparam int          STEP_W          = 3;

    // datapath operations
    localparam logic [2:0] OP_WAIT    = 3'd0;
    localparam logic [2:0] OP_LD_INT  = 3'd1;
    localparam logic [2:0] OP_DIV     = 3'd2;
    localparam logic [2:0] OP_NOP     = 3'd3;
    localparam logic [2:0] OP_JOIN    = 3'd4;
    localparam logic [2:0] OP_EMIT    = 3'd5;
    localparam logic [2:0] OP_RESTART = 3'd6;

    // hold conditions
    localparam logic [1:0] WT_NONE = 2'd0;
    localparam logic [1:0] WT_TAP  = 2'd1;
    localparam logic [1:0] WT_DIV  = 2'd2;
    localparam logic [1:0] WT_OUT  = 2'd3;

    // branch conditions
    localparam logic [1:0] BR_NEVER  = 2'd0;
    localparam logic [1:0] BR_ALWAYS = 2'd1;
    localparam logic [1:0] BR_EMPTY  = 2'd2;
    localparam logic [1:0] BR_SLOW   = 2'd3;

    // program steps
    localparam logic [STEP_W-1:0] S_WAIT    = 3'd0;
    localparam logic [STEP_W-1:0] S_CHECK   = 3'd1;
    localparam logic [STEP_W-1:0] S_DIV_INT = 3'd2;
    localparam logic [STEP_W-1:0] S_TEST    = 3'd3;
    localparam logic [STEP_W-1:0] S_JOIN    = 3'd4;
    localparam logic [STEP_W-1:0] S_DIV_SPN = 3'd5;
    localparam logic [STEP_W-1:0] S_EMIT    = 3'd6;
    localparam logic [STEP_W-1:0] S_RESTART = 3'd7;

    typedef struct packed {
        logic [2:0]        op;
        logic [1:0]        wt;
        logic [1:0]        br;
        logic [STEP_W-1:0] tgt;
    } t_ctrl;

    function automatic t_ctrl tte_ucode(input logic [STEP_W-1:0] step);
        t_ctrl w;
        case (step)
            S_WAIT:    w = '{op: OP_WAIT,    wt: WT_TAP,  br: BR_NEVER,  tgt: S_WAIT};
            S_CHECK:   w = '{op: OP_LD_INT,  wt: WT_NONE, br: BR_EMPTY,  tgt: S_RESTART};
            S_DIV_INT: w = '{op: OP_DIV,     wt: WT_DIV,  br: BR_NEVER,  tgt: S_WAIT};
            S_TEST:    w = '{op: OP_NOP,     wt: WT_NONE, br: BR_SLOW,   tgt: S_RESTART};
            S_JOIN:    w = '{op: OP_JOIN,    wt: WT_NONE, br: BR_NEVER,  tgt: S_WAIT};
            S_DIV_SPN: w = '{op: OP_DIV,     wt: WT_DIV,  br: BR_NEVER,  tgt: S_WAIT};
            S_EMIT:    w = '{op: OP_EMIT,    wt: WT_OUT,  br: BR_ALWAYS, tgt: S_WAIT};
            S_RESTART: w = '{op: OP_RESTART, wt: WT_NONE, br: BR_ALWAYS, tgt: S_WAIT};
            default:   w = '{op: OP_NOP,     wt: WT_NONE, br: BR_ALWAYS, tgt: S_WAIT};
        endcase
        return w;
    endfunction

endpackage

// File: design/tap_tempo_estimator_top.sv
// Tap tempo estimator: microcoded sequencer with a shared restoring divider.
//
//  channel | dir | handshake                  | word
//  --------+-----+----------------------------+---------------------------
//  tap     | in  | i_tap_valid / o_tap_stall  | i_tap_time_ms
//  res     | out | o_res_valid / i_res_stall  | o_tempo, o_taps_used
//  cfg     | in  | i_cfg_we                   | i_cfg_wdata (min_tempo)
//
//  One tap at a time. A joining tap runs two passes of the one-bit-per-cycle divider
//  (interval, span); a first tap just restarts, a slow tap restarts after one pass.
//  Synchronous active-low reset clears the step counter, tap count, output valid
//  and loads min_tempo with 30. The result register lets the next tap in while a
//  word waits; the emit step holds only if that register is still occupied.
`timescale 1ns / 1ps

module tap_tempo_estimator_top #(
    parameter int WINDOW_TAPS = tte_pkg::WINDOW_TAPS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [tte_pkg::MIN_TEMPO_W-1:0] i_cfg_wdata,
    input  logic                         i_tap_valid,
    output logic                         o_tap_stall,
    input  logic [tte_pkg::TIME_W-1:0]   i_tap_time_ms,
    output logic                         o_res_valid,
    input  logic                         i_res_stall,
    output logic [tte_pkg::TEMPO_W-1:0]  o_tempo,
    output logic [tte_pkg::TAPS_W-1:0]   o_taps_used
);
    import tte_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW_TAPS + 1);
    localparam int IDX_W  = $clog2(WINDOW_TAPS);
    localparam int NUM_W  = TEMPO_W + CNT_W;
    localparam int ITER_W = $clog2(NUM_W + 1);

    logic [STEP_W-1:0]      r_step,  n_step;
    logic [CNT_W-1:0]       r_cnt,   n_cnt;
    logic [MIN_TEMPO_W-1:0] r_min,   n_min;
    logic [TIME_W-1:0]      r_now,   n_now;
    logic [TIME_W-1:0]      r_times [WINDOW_TAPS];
    logic [TIME_W-1:0]      n_times [WINDOW_TAPS];
    logic [TIME_W-1:0]      r_rem,   n_rem;
    logic [TIME_W-1:0]      r_den,   n_den;
    logic [NUM_W-1:0]       r_quo,   n_quo;
    logic [ITER_W-1:0]      r_iter,  n_iter;
    logic                   r_out_valid, n_out_valid;
    logic [TEMPO_W-1:0]     r_out_tempo, n_out_tempo;
    logic [TAPS_W-1:0]      r_out_taps,  n_out_taps;

    t_ctrl                  ctrl;
    logic                   met;
    logic                   br_take;
    logic                   out_free;
    logic                   joins;
    logic [CNT_W-1:0]       cnt_join;
    logic [CNT_W-1:0]       old_sel;
    logic [IDX_W-1:0]       old_idx;
    logic [TIME_W:0]        div_sh;
    logic [TIME_W:0]        div_diff;
    logic                   div_ge;
    logic [TEMPO_W-1:0]     tempo_sat;

    assign ctrl     = tte_ucode(r_step);
    assign out_free = !r_out_valid || !i_res_stall;
    assign joins    = r_quo > NUM_W'(r_min);

    assign cnt_join = (r_cnt == CNT_W'(WINDOW_TAPS)) ? r_cnt : r_cnt + CNT_W'(1);
    assign old_sel  = cnt_join - CNT_W'(2);
    assign old_idx  = old_sel[IDX_W-1:0];

    assign div_sh   = {r_rem, r_quo[NUM_W-1]};
    assign div_diff = div_sh - {1'b0, r_den};
    assign div_ge   = !div_diff[TIME_W];

    assign tempo_sat = (r_quo > NUM_W'(MS_PER_MINUTE)) ? TEMPO_W'(MS_PER_MINUTE)
                                                       : r_quo[TEMPO_W-1:0];

    always_comb begin
        case (ctrl.wt)
            WT_NONE: met = 1'b1;
            WT_TAP:  met = i_tap_valid;
            WT_DIV:  met = (r_iter == ITER_W'(1));
            WT_OUT:  met = out_free;
            default: met = 1'b1;
        endcase
        case (ctrl.br)
            BR_NEVER:  br_take = 1'b0;
            BR_ALWAYS: br_take = 1'b1;
            BR_EMPTY:  br_take = (r_cnt == '0);
            BR_SLOW:   br_take = !joins;
            default:   br_take = 1'b0;
        endcase
    end

    always_comb begin
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_min       = i_cfg_we ? i_cfg_wdata : r_min;
        n_now       = r_now;
        n_times     = r_times;
        n_rem       = r_rem;
        n_den       = r_den;
        n_quo       = r_quo;
        n_iter      = r_iter;
        n_out_valid = r_out_valid && i_res_stall;
        n_out_tempo = r_out_tempo;
        n_out_taps  = r_out_taps;

        if (met) begin
            n_step = br_take ? ctrl.tgt : r_step + STEP_W'(1);
        end

        case (ctrl.op)
            OP_WAIT: begin
                n_now = i_tap_time_ms;
            end
            OP_LD_INT: begin
                n_rem  = '0;
                n_den  = r_now - r_times[0];
                n_quo  = NUM_W'(MS_PER_MINUTE);
                n_iter = br_take ? '0 : ITER_W'(NUM_W);
            end
            OP_DIV: begin
                n_rem  = div_ge ? div_diff[TIME_W-1:0] : div_sh[TIME_W-1:0];
                n_quo  = {r_quo[NUM_W-2:0], div_ge};
                n_iter = r_iter - ITER_W'(1);
            end
            OP_JOIN: begin
                n_cnt   = cnt_join;
                n_times[0] = r_now;
                for (int i = 1; i < WINDOW_TAPS; i++) begin
                    n_times[i] = r_times[i-1];
                end
                n_rem  = '0;
                n_den  = r_now - r_times[old_idx];
                n_quo  = NUM_W'(MS_PER_MINUTE) * NUM_W'(cnt_join - CNT_W'(1));
                n_iter = ITER_W'(NUM_W);
            end
            OP_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_tempo = tempo_sat;
                    n_out_taps  = TAPS_W'(r_cnt);
                end
            end
            OP_RESTART: begin
                n_cnt      = CNT_W'(1);
                n_times[0] = r_now;
                for (int i = 1; i < WINDOW_TAPS; i++) begin
                    n_times[i] = r_times[i-1];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_WAIT;
            r_cnt       <= '0;
            r_min       <= MIN_TEMPO_RESET;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_min       <= n_min;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now       <= n_now;
        r_times     <= n_times;
        r_rem       <= n_rem;
        r_den       <= n_den;
        r_quo       <= n_quo;
        r_out_tempo <= n_out_tempo;
        r_out_taps  <= n_out_taps;
    end

    assign o_tap_stall = (ctrl.op != OP_WAIT);
    assign o_res_valid = r_out_valid;
    assign o_tempo     = r_out_tempo;
    assign o_taps_used = r_out_taps;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(WINDOW_TAPS))
        else $error("tap count beyond window");

    a_tempo_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_tempo <= TEMPO_W'(MS_PER_MINUTE)))
        else $error("tempo above saturation");

    a_tap_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tap_valid && !o_tap_stall) |=> (r_step == S_CHECK))
        else $error("accepted tap not checked next");

    a_div_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_iter != '0) |-> (r_step == S_DIV_INT || r_step == S_DIV_SPN))
        else $error("divider running outside a divide step");
`endif

endmodule
